/* hw/rtl/hcd_pkg.sv */
// Shared types, codes and mod-26 helpers for the 2x2 Hill cipher decryptor.
package hcd_pkg;

  localparam int unsigned KEY_W = 5;
  localparam int unsigned SUM_W = 11;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] REG_KEY_A = 2'd0;
  localparam logic [1:0] REG_KEY_B = 2'd1;
  localparam logic [1:0] REG_KEY_C = 2'd2;
  localparam logic [1:0] REG_KEY_D = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NON_LETTER = 2'd1;
  localparam logic [1:0] STATUS_KEY_INVALID = 2'd2;

  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

  localparam logic [KEY_W-1:0] MODULUS = 5'd26;

  // Multiplicative inverses mod 26; zero marks a determinant with no inverse.
  localparam logic [KEY_W-1:0] INV_TABLE [0:25] = '{
    5'd0, 5'd1, 5'd0, 5'd9, 5'd0, 5'd21, 5'd0, 5'd15, 5'd0, 5'd3, 5'd0, 5'd19, 5'd0,
    5'd0, 5'd0, 5'd7, 5'd0, 5'd23, 5'd0, 5'd11, 5'd0, 5'd5, 5'd0, 5'd17, 5'd0, 5'd25
  };

  typedef enum logic [1:0] {
    JOB_PAIR       = 2'd0,
    JOB_NON_LETTER = 2'd1,
    JOB_KEY_BAD    = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [KEY_W-1:0] p0;
    logic             upper0;
    logic [KEY_W-1:0] p1;
    logic             upper1;
  } job_t;

  typedef struct packed {
    logic [3:0][KEY_W-1:0] inv;
    logic                  valid;
    logic                  busy;
  } key_state_t;

  // x mod 26 for x below 2048: the reciprocal 2521/65536 gives the exact quotient
  // over this range, so no correction step is needed.
  function automatic logic [KEY_W-1:0] mod26(input logic [SUM_W-1:0] x);
    logic [22:0]      prod;
    logic [6:0]       quo;
    logic [SUM_W-1:0] rem;
    prod = 23'(x) * 23'd2521;
    quo = prod[22:16];
    rem = x - (SUM_W'(quo) * SUM_W'(MODULUS));
    return rem[KEY_W-1:0];
  endfunction

  // Reduces a stored 5-bit key value into 0..25.
  function automatic logic [KEY_W-1:0] reduce26(input logic [KEY_W-1:0] v);
    return (v >= MODULUS) ? (v - MODULUS) : v;
  endfunction

endpackage

/* hw/rtl/hcd_keygen.sv */
// Key registers and the pipelined derivation of the inverse key mod 26.
module hcd_keygen (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [hcd_pkg::KEY_W-1:0] cfg_data,
  output hcd_pkg::key_state_t     key
);

  localparam int unsigned KEY_LAT = 4;

  logic [hcd_pkg::KEY_W-1:0] key_a, key_b, key_c, key_d;
  logic [KEY_LAT-1:0]        tag;
  logic                      cfg_we;

  // Stage 1: reduced keys and the shifted determinant.
  logic [hcd_pkg::KEY_W-1:0] ar, br, cr, dr;
  logic [hcd_pkg::SUM_W-1:0] det_raw;
  // Stage 2: inverse determinant and adjugate.
  logic [hcd_pkg::KEY_W-1:0] det_inv;
  logic [3:0][hcd_pkg::KEY_W-1:0] adj;
  // Stage 3: adjugate times inverse determinant.
  logic [3:0][hcd_pkg::SUM_W-1:0] prod;
  logic                           prod_ok;

  logic [3:0][hcd_pkg::KEY_W-1:0] inv;
  logic                           inv_valid;

  logic [hcd_pkg::KEY_W-1:0] det;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a <= 5'd1;
      key_b <= 5'd0;
      key_c <= 5'd0;
      key_d <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcd_pkg::REG_KEY_A: key_a <= cfg_data;
        hcd_pkg::REG_KEY_B: key_b <= cfg_data;
        hcd_pkg::REG_KEY_C: key_c <= cfg_data;
        hcd_pkg::REG_KEY_D: key_d <= cfg_data;
      endcase
    end
  end

  // A write travels down the tag line alongside its data.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else begin
      tag <= {tag[KEY_LAT-2:0], cfg_we};
    end
  end

  always_ff @(posedge clk) begin
    ar <= hcd_pkg::reduce26(key_a);
    br <= hcd_pkg::reduce26(key_b);
    cr <= hcd_pkg::reduce26(key_c);
    dr <= hcd_pkg::reduce26(key_d);
    // Adding 650 keeps a*d - b*c non-negative without changing it mod 26.
    det_raw <= hcd_pkg::SUM_W'(hcd_pkg::reduce26(key_a)) *
               hcd_pkg::SUM_W'(hcd_pkg::reduce26(key_d)) + 11'd650 -
               hcd_pkg::SUM_W'(hcd_pkg::reduce26(key_b)) *
               hcd_pkg::SUM_W'(hcd_pkg::reduce26(key_c));
  end

  assign det = hcd_pkg::mod26(det_raw);

  always_ff @(posedge clk) begin
    det_inv <= hcd_pkg::INV_TABLE[det];
    adj[0] <= dr;
    adj[1] <= (br == '0) ? '0 : hcd_pkg::MODULUS - br;
    adj[2] <= (cr == '0) ? '0 : hcd_pkg::MODULUS - cr;
    adj[3] <= ar;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      prod[i] <= hcd_pkg::SUM_W'(adj[i]) * hcd_pkg::SUM_W'(det_inv);
    end
    prod_ok <= (det_inv != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv[0] <= 5'd1;
      inv[1] <= 5'd0;
      inv[2] <= 5'd0;
      inv[3] <= 5'd1;
      inv_valid <= 1'b1;
    end else if (tag[KEY_LAT-1]) begin
      inv_valid <= prod_ok;
      if (prod_ok) begin
        for (int i = 0; i < 4; i++) begin
          inv[i] <= hcd_pkg::mod26(prod[i]);
        end
      end
    end
  end

  assign key.inv = inv;
  assign key.valid = inv_valid;
  assign key.busy = cfg_we | (|tag);

endmodule

/* hw/rtl/hcd_front.sv */
// Input side: classifies characters, pairs letters and issues jobs to the queue.
module hcd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcd_pkg::in_item_t   in_data,
  input  hcd_pkg::key_state_t key,
  input  logic                q_full,
  output logic                push,
  output hcd_pkg::job_t       job
);

  logic [hcd_pkg::KEY_W-1:0] held_letter;
  logic                      held_upper;
  logic                      held_present;
  logic                      held_present_next;

  logic       accept;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] offset;
  logic [hcd_pkg::KEY_W-1:0] letter;

  assign in_ready = !key.busy && !q_full;
  assign accept = in_valid & in_ready;

  assign is_upper = (in_data.in_byte >= hcd_pkg::CHAR_UPPER_A) &&
                    (in_data.in_byte <= hcd_pkg::CHAR_UPPER_Z);
  assign is_lower = (in_data.in_byte >= hcd_pkg::CHAR_LOWER_A) &&
                    (in_data.in_byte <= hcd_pkg::CHAR_LOWER_Z);
  assign offset = in_data.in_byte - (is_upper ? hcd_pkg::CHAR_UPPER_A : hcd_pkg::CHAR_LOWER_A);
  assign letter = offset[hcd_pkg::KEY_W-1:0];

  always_comb begin
    push = 1'b0;
    held_present_next = held_present;
    job.kind = hcd_pkg::JOB_PAIR;
    job.p0 = held_letter;
    job.upper0 = held_upper;
    job.p1 = letter;
    job.upper1 = is_upper;
    if (accept) begin
      priority if (!is_upper && !is_lower) begin
        push = 1'b1;
        job.kind = hcd_pkg::JOB_NON_LETTER;
      end else if (!key.valid) begin
        push = 1'b1;
        job.kind = hcd_pkg::JOB_KEY_BAD;
        held_present_next = 1'b0;
      end else if (!held_present) begin
        held_present_next = 1'b1;
      end else begin
        push = 1'b1;
        held_present_next = 1'b0;
      end
      // A letter still waiting for its partner dies with the message.
      if (in_data.end_of_message) begin
        held_present_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_present <= 1'b0;
    end else begin
      held_present <= held_present_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_upper <= 1'b0;
    end else if (accept && (is_upper || is_lower) && key.valid && !held_present) begin
      held_letter <= letter;
      held_upper <= is_upper;
    end
  end

endmodule

/* hw/rtl/hcd_queue.sv */
// Short job queue between the front and back parts.
module hcd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hcd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output hcd_pkg::job_t head
);

  localparam int unsigned PTR_W = $clog2(hcd_pkg::QUEUE_DEPTH);

  hcd_pkg::job_t    slots [hcd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full = (count == (PTR_W + 1)'(hcd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/hcd_back.sv */
// Output side: multiplies letter pairs by the inverse key and emits result words.
module hcd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  hcd_pkg::job_t       head,
  output logic                pop,
  input  hcd_pkg::key_state_t key,
  output logic                out_valid,
  input  logic                out_ready,
  output hcd_pkg::out_item_t  out_data
);

  logic                      a_valid;
  logic                      a_half;
  hcd_pkg::job_t             a_job;
  logic [hcd_pkg::SUM_W-1:0] a_s0;
  logic [hcd_pkg::SUM_W-1:0] a_s1;

  logic                      load_ok;
  logic                      a_emit;
  logic                      a_done;
  logic                      a_free;
  hcd_pkg::out_item_t        result;
  logic [hcd_pkg::KEY_W-1:0] letter;
  logic                      upper;

  assign load_ok = !out_valid || out_ready;
  assign a_emit = a_valid && load_ok;
  // A pair holds its slot for two output words.
  assign a_done = a_emit && ((a_job.kind != hcd_pkg::JOB_PAIR) || a_half);
  assign a_free = !a_valid || a_done;
  assign pop = !q_empty && a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_half <= 1'b0;
    end else if (pop) begin
      a_valid <= 1'b1;
      a_half <= 1'b0;
    end else if (a_done) begin
      a_valid <= 1'b0;
      a_half <= 1'b0;
    end else if (a_emit) begin
      a_half <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_job <= head;
      a_s0 <= hcd_pkg::SUM_W'(head.p0) * hcd_pkg::SUM_W'(key.inv[0]) +
              hcd_pkg::SUM_W'(head.p1) * hcd_pkg::SUM_W'(key.inv[2]);
      a_s1 <= hcd_pkg::SUM_W'(head.p0) * hcd_pkg::SUM_W'(key.inv[1]) +
              hcd_pkg::SUM_W'(head.p1) * hcd_pkg::SUM_W'(key.inv[3]);
    end
  end

  assign letter = hcd_pkg::mod26(a_half ? a_s1 : a_s0);
  assign upper = a_half ? a_job.upper1 : a_job.upper0;

  always_comb begin
    result.out_byte = '0;
    result.status = hcd_pkg::STATUS_OK;
    result.last = 1'b1;
    unique case (a_job.kind)
      hcd_pkg::JOB_PAIR: begin
        result.out_byte = {3'b000, letter} +
                          (upper ? hcd_pkg::CHAR_UPPER_A : hcd_pkg::CHAR_LOWER_A);
        result.last = a_half;
      end
      hcd_pkg::JOB_NON_LETTER: result.status = hcd_pkg::STATUS_NON_LETTER;
      hcd_pkg::JOB_KEY_BAD:    result.status = hcd_pkg::STATUS_KEY_INVALID;
      default:                 result.status = hcd_pkg::STATUS_KEY_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_emit) begin
      out_data <= result;
    end
  end

endmodule

/* hw/rtl/hill_cipher_2x2_decrypt.sv */
// Top level of the 2x2 Hill cipher decryptor, mod 26.
// The block takes one character per clock cycle while in_ready is high and
// gives one result word per cycle while out_ready is high: a non-letter or a
// letter under a non-invertible key yields one word, the first letter of a pair
// yields nothing, and the second yields two words, one per letter of the pair,
// so a stream of letters averages one word per letter. Output is limited to one
// word per cycle by the output register; a four-entry job queue lets the input
// side keep accepting while results wait. An input passes through the queue,
// the back part's job register and the output register. After a key register
// write the inverse key is re-derived in a four-stage pipeline and in_ready is
// low until it is in place; configuration writes are always taken.
module hill_cipher_2x2_decrypt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  hcd_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hcd_pkg::out_item_t       out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [hcd_pkg::KEY_W-1:0] cfg_data
);

  hcd_pkg::key_state_t key;
  hcd_pkg::job_t       push_job;
  hcd_pkg::job_t       head;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;

  hcd_keygen u_keygen (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  hcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .key      (key),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  hcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  hcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
